// ----- design/ovls_pkg.sv -----
// ----------------------------------------------------------------------------
// Ordered value list store: shared definitions
// Field widths, command and status codes, controller states and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package ovls_pkg;

  localparam int unsigned CAPACITY_DEF = 16;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned FPOS_W   = 4;
  localparam int unsigned COUNT_W  = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND     = 3'd0,
    CMD_SEARCH     = 3'd1,
    CMD_REMOVE_POS = 3'd2,
    CMD_REMOVE_EQ  = 3'd3,
    CMD_CLEAR      = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SRCH_RD,
    S_SRCH_CHK,
    S_PACK_RD,
    S_PACK_WR,
    S_TAIL_RD,
    S_RESULT
  } state_t;

  // Commands from the controller to the datapath, valid for one cycle.
  typedef struct packed {
    logic    capture;
    logic    append;
    logic    clear;
    logic    set_status;
    status_t status_code;
    logic    srch_init;
    logic    srch_step;
    logic    srch_hit;
    logic    pack_init;
    logic    pack_step;
    logic    pack_finish;
    logic    rd_en;
    logic    rd_tail;
    logic    out_load;
  } ctl_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             full;
    logic             empty;
    logic             pos_bad;
    logic             match;
    logic             idx_zero;
    logic             idx_last;
  } dp_stat_t;

endpackage

// ----- design/ovls_ctrl.sv -----
// ----------------------------------------------------------------------------
// Ordered value list store: controller
// Sequences each command through decode, the entry scan or compaction loop,
// the tail read and the result strobe.
// ----------------------------------------------------------------------------
module ovls_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output logic              done,
  input  ovls_pkg::dp_stat_t dp_st,
  output ovls_pkg::ctl_cmd_t ctl
);
  import ovls_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_RESULT);
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    ctl = '0;
    ctl.status_code = ST_OK;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          ctl.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_TAIL_RD;
        unique case (dp_st.cmd)
          CMD_APPEND: begin
            if (dp_st.full) begin
              ctl.set_status  = 1'b1;
              ctl.status_code = ST_FULL;
            end else begin
              ctl.append = 1'b1;
            end
          end
          CMD_SEARCH: begin
            if (dp_st.empty) begin
              ctl.set_status  = 1'b1;
              ctl.status_code = ST_MISS;
            end else begin
              ctl.srch_init = 1'b1;
              state_next    = S_SRCH_RD;
            end
          end
          CMD_REMOVE_POS: begin
            if (dp_st.pos_bad) begin
              ctl.set_status  = 1'b1;
              ctl.status_code = ST_MISS;
            end else begin
              ctl.pack_init = 1'b1;
              state_next    = S_PACK_RD;
            end
          end
          CMD_REMOVE_EQ: begin
            if (dp_st.empty) begin
              ctl.set_status  = 1'b1;
              ctl.status_code = ST_MISS;
            end else begin
              ctl.pack_init = 1'b1;
              state_next    = S_PACK_RD;
            end
          end
          CMD_CLEAR: begin
            ctl.clear = 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_SRCH_RD: begin
        ctl.rd_en  = 1'b1;
        state_next = S_SRCH_CHK;
      end
      S_SRCH_CHK: begin
        priority if (dp_st.match) begin
          ctl.srch_hit = 1'b1;
          state_next   = S_TAIL_RD;
        end else if (dp_st.idx_zero) begin
          ctl.set_status  = 1'b1;
          ctl.status_code = ST_MISS;
          state_next      = S_TAIL_RD;
        end else begin
          ctl.srch_step = 1'b1;
          state_next    = S_SRCH_RD;
        end
      end
      S_PACK_RD: begin
        ctl.rd_en  = 1'b1;
        state_next = S_PACK_WR;
      end
      S_PACK_WR: begin
        ctl.pack_step = 1'b1;
        if (dp_st.idx_last) begin
          ctl.pack_finish = 1'b1;
          state_next      = S_TAIL_RD;
        end else begin
          state_next = S_PACK_RD;
        end
      end
      S_TAIL_RD: begin
        ctl.rd_en   = 1'b1;
        ctl.rd_tail = 1'b1;
        state_next  = S_RESULT;
      end
      S_RESULT: begin
        ctl.out_load = 1'b1;
        state_next   = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- design/ovls_dpath.sv -----
// ----------------------------------------------------------------------------
// Ordered value list store: datapath
// Entry memory, count, scan and compaction pointers, command registers and
// the result registers.
// ----------------------------------------------------------------------------
module ovls_dpath #(
  parameter int unsigned CAPACITY = ovls_pkg::CAPACITY_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [ovls_pkg::CMD_W-1:0]           cmd,
  input  logic signed [ovls_pkg::VALUE_W-1:0]  value,
  input  logic [ovls_pkg::POS_W-1:0]           position,
  input  ovls_pkg::ctl_cmd_t                   ctl,
  output ovls_pkg::dp_stat_t                   dp_st,
  output logic [ovls_pkg::STATUS_W-1:0]        status,
  output logic                                 found,
  output logic [ovls_pkg::FPOS_W-1:0]          found_position,
  output logic [ovls_pkg::COUNT_W-1:0]         entry_count,
  output logic signed [ovls_pkg::VALUE_W-1:0]  tail_value
);
  import ovls_pkg::*;

  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;
  localparam int unsigned FXW  = (AW > FPOS_W) ? AW : FPOS_W;
  localparam int unsigned CXW  = (CW > COUNT_W) ? CW : COUNT_W;

  logic [VALUE_W-1:0] mem [CAPACITY];

  logic [CMD_W-1:0]   cmd_q;
  logic [VALUE_W-1:0] value_q;
  logic [POS_W-1:0]   pos_q;
  logic [CW-1:0]      count;
  logic [AW-1:0]      idx;
  logic [AW-1:0]      kept;
  logic [AW-1:0]      srch_dist;
  status_t            status_q;
  logic               found_q;
  logic [AW-1:0]      fpos_q;
  logic [VALUE_W-1:0] rd_data;

  logic [AW-1:0]      last_idx;
  logic               is_rm_pos;
  logic               match;
  logic               keep;
  logic [CW-1:0]      count_new;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [VALUE_W-1:0] wdata;
  logic [AW-1:0]      raddr;
  logic [FXW-1:0]     fpos_x;
  logic [CXW-1:0]     count_x;

  assign last_idx  = AW'(count - CW'(1));
  assign is_rm_pos = (cmd_q == CMD_REMOVE_POS);
  assign match     = (rd_data == value_q);

  // Removal by position drops only the first slot it visits; after that the
  // read pointer always runs one ahead of the write pointer.
  assign keep      = is_rm_pos ? (idx != kept) : !match;
  assign count_new = CW'(kept) + CW'(keep);

  assign dp_st.cmd      = cmd_q;
  assign dp_st.full     = (count == CW'(CAPACITY));
  assign dp_st.empty    = (count == '0);
  assign dp_st.pos_bad  = (CMPW'(pos_q) >= CMPW'(count));
  assign dp_st.match    = match;
  assign dp_st.idx_zero = (idx == '0);
  assign dp_st.idx_last = (idx == last_idx);

  assign we    = ctl.append || (ctl.pack_step && keep);
  assign waddr = ctl.append ? count[AW-1:0] : kept;
  assign wdata = ctl.append ? value_q : rd_data;
  assign raddr = ctl.rd_tail ? last_idx : idx;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.append) begin
      count <= count + CW'(1);
    end else if (ctl.clear) begin
      count <= '0;
    end else if (ctl.pack_finish) begin
      count <= count_new;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_q    <= cmd;
      value_q  <= value;
      pos_q    <= position;
      status_q <= ST_OK;
      found_q  <= 1'b0;
      fpos_q   <= '0;
    end
    if (ctl.set_status) begin
      status_q <= ctl.status_code;
    end
    if (ctl.srch_init) begin
      idx       <= last_idx;
      srch_dist <= '0;
    end
    if (ctl.srch_step) begin
      idx       <= idx - AW'(1);
      srch_dist <= srch_dist + AW'(1);
    end
    if (ctl.srch_hit) begin
      found_q <= 1'b1;
      fpos_q  <= srch_dist;
    end
    if (ctl.pack_init) begin
      if (is_rm_pos) begin
        idx  <= last_idx - AW'(pos_q);
        kept <= last_idx - AW'(pos_q);
      end else begin
        idx  <= '0;
        kept <= '0;
      end
    end
    if (ctl.pack_step) begin
      idx <= idx + AW'(1);
      if (keep) begin
        kept <= kept + AW'(1);
      end
    end
    if (ctl.pack_finish) begin
      status_q <= (count_new == count) ? ST_MISS : ST_OK;
    end
  end

  assign fpos_x  = FXW'(fpos_q);
  assign count_x = CXW'(count);

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      status         <= status_q;
      found          <= found_q;
      found_position <= fpos_x[FPOS_W-1:0];
      entry_count    <= count_x[COUNT_W-1:0];
      tail_value     <= (count == '0) ? '0 : rd_data;
    end
  end

endmodule

// ----- design/ordered_value_list_store_core.sv -----
// ----------------------------------------------------------------------------
// Ordered value list store
// Bounded list of signed 32-bit values in insertion order with append,
// search from the tail, removal by position or by value, and clear.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low, and exactly one
// result follows on the result ports with done high for a single cycle; the
// receiver cannot stall, so it must capture the result in that cycle. busy
// is low again in the cycle done is high. Append, clear and unused codes
// go from decode straight to the tail read and the result. A search
// reads the entries from the tail up to and including the first match.
// Either removal reads the entries from the first slot touched (the
// removed position, or the oldest entry for removal by value) through
// the tail. Each entry takes a read state and a check or write state in
// those loops because the entry memory has one registered read port and
// one write port.
module ordered_value_list_store_core #(
  parameter int unsigned CAPACITY = ovls_pkg::CAPACITY_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [ovls_pkg::CMD_W-1:0]           cmd,
  input  logic signed [ovls_pkg::VALUE_W-1:0]  value,
  input  logic [ovls_pkg::POS_W-1:0]           position,
  output logic                                 done,
  output logic [ovls_pkg::STATUS_W-1:0]        status,
  output logic                                 found,
  output logic [ovls_pkg::FPOS_W-1:0]          found_position,
  output logic [ovls_pkg::COUNT_W-1:0]         entry_count,
  output logic signed [ovls_pkg::VALUE_W-1:0]  tail_value
);
  import ovls_pkg::*;

  ctl_cmd_t ctl;
  dp_stat_t dp_st;

  ovls_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .dp_st (dp_st),
    .ctl   (ctl)
  );

  ovls_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .value          (value),
    .position       (position),
    .ctl            (ctl),
    .dp_st          (dp_st),
    .status         (status),
    .found          (found),
    .found_position (found_position),
    .entry_count    (entry_count),
    .tail_value     (tail_value)
  );

endmodule
